// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the token pacing RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TPPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TPPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tppq_pkg.sv =====
// Package for the token paced priority queues: payload types, codes,
// constants and small helper functions. Depends on nothing.
package tppq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = Q_AW + 1;
    localparam int TAG_BITS    = 16;
    localparam int MAX_SERVICE = 64;
    localparam int SVC_CW      = $clog2(MAX_SERVICE + 1);
    localparam int ACK_BITS    = 24;
    localparam logic [ACK_BITS-1:0] ACK_CAP   = ACK_BITS'(10 * 1024 * 1024);
    localparam logic [5:0]          HDR_BYTES = 6'd54;
    // Reciprocal of 100 scaled by 2^37; the quotient is bits 63:37 of the
    // product and is exact for every 32-bit dividend.
    localparam logic [31:0]         DECAY_RECIP = 32'd1374389535;
    localparam logic [31:0]         DECAY_MIN = 32'd10240;

    localparam logic [31:0] CAP_RESET   = 32'd33554432;
    localparam logic [31:0] DELAY_RESET = 32'd50000;
    localparam logic [15:0] MSS_RESET   = 16'd1460;

    typedef enum logic [1:0] {
        ACT_PACKET  = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_DECAY   = 2'd2,
        ACT_SERVICE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        V_PASS    = 3'd0,
        V_QUEUED  = 3'd1,
        V_DROP    = 3'd2,
        V_TOKENS  = 3'd3,
        V_TIMEOUT = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_CAPACITY  = 2'd0,
        CFG_MAX_DELAY = 2'd1,
        CFG_SEGMENT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PKT,
        BS_DIV,
        BS_OUT,
        BS_SRD,
        BS_SEV,
        BS_SFIN
    } t_bstate;

    typedef struct packed {
        logic [1:0]          action;
        logic [TAG_BITS-1:0] packet_tag;
        logic [31:0]         trigger_bytes;
        logic                high_priority;
        logic [31:0]         ack_advance_bytes;
        logic [31:0]         now_us;
    } t_in_item;

    typedef struct packed {
        logic [TAG_BITS-1:0] result_tag;
        logic [2:0]          verdict;
        logic                last;
        logic [31:0]         tokens_level;
    } t_out_item;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         charge;
        logic [31:0]         stamp;
    } t_qent;

    // Head of the front queue as seen by the back end.
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_fq;

    function automatic logic tok_fits(input logic [31:0] cap, input logic [31:0] tok,
                                      input logic [31:0] amt);
        logic [31:0] room;
        room = cap - tok;
        return (cap >= tok) && (room >= amt);
    endfunction

    function automatic logic [ACK_BITS-1:0] ack_cap(input logic [31:0] adv);
        return (adv > {{(32-ACK_BITS){1'b0}}, ACK_CAP}) ? ACK_CAP : adv[ACK_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/tppq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tppq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/tppq_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module tppq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem, r_dvs;
    logic [31:0] r_quo;
    logic [16:0] trial, diff;
    logic        ge;

    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[15:0] : trial[15:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== hw/rtl/tppq_front.sv =====
// Front end: accepts input transfers into a two-entry queue.
// Depends on tppq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tppq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tppq_pkg::t_in_item i_in,
    input  logic              i_pop,
    output tppq_pkg::t_fq     o_fq
);
    import tppq_pkg::*;

    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_in_ready = r_cnt != 2'd2;
    assign push       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in;
        end
    end

    assign o_fq.valid = r_cnt != 2'd0;
    assign o_fq.item  = r_mem[r_rp];

    `TPPQ_ASSERT_IMPL(a_no_underflow, i_pop, r_cnt != 2'd0, "pop from empty front queue")
    `TPPQ_ASSERT_IMPL(a_no_overflow, push, r_cnt != 2'd2, "push into full front queue")
    `TPPQ_ASSERT(a_cnt_bound, r_cnt <= 2'd2, "front queue fill above two")
endmodule

// ===== hw/rtl/tppq_back.sv =====
// Back end: token bucket, both priority queues, segment-size divider, result register.
// Depends on tppq_pkg, tppq_ram, tppq_div and assert_macros.svh.
`include "assert_macros.svh"
module tppq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  tppq_pkg::t_fq       i_fq,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tppq_pkg::t_out_item o_out
);
    import tppq_pkg::*;

    t_bstate           r_state, n_state;
    logic [31:0]       r_cap, r_maxd;
    logic [15:0]       r_mss;
    logic [31:0]       r_tokens, n_tokens;
    logic [Q_AW-1:0]   r_hh, n_hh, r_lh, n_lh;
    logic [Q_CW-1:0]   r_hc, n_hc, r_lc, n_lc;
    t_in_item          r_item, n_item;
    logic              r_sel, n_sel;
    logic [SVC_CW-1:0] r_k, n_k;
    logic              r_held_v, n_held_v;
    t_out_item         r_held, n_held, r_res, n_res;
    logic              r_out_v, n_out_v;
    t_out_item         r_out, n_out;
    logic [31:0]       r_dec_q;

    logic              out_free;
    logic [15:0]       mss_eff;
    logic              div_start, div_done;
    logic [31:0]       div_dividend, div_quo;
    logic [15:0]       div_divisor;
    logic [29:0]       ack_prod;
    logic [63:0]       dec_prod;
    logic              ret_ready;

    logic              we_h, we_l;
    logic [Q_AW-1:0]   waddr;
    t_qent             wdata, rd_h, rd_l, ent;

    logic              pkt_clear, pkt_fits, pkt_full;
    logic [Q_CW-1:0]   pkt_cnt, slot_sum;
    logic [Q_AW-1:0]   pkt_head;
    logic [32:0]       give_amt;
    logic [31:0]       dec_amt, ret_tokens;
    logic              sev_fits, sev_tmo, sev_rel, sev_go;
    logic [31:0]       sev_wait;
    logic [Q_CW-1:0]   sev_cnt;
    logic [Q_AW-1:0]   sev_head;

    assign out_free = !r_out_v || i_out_ready;
    assign mss_eff  = (r_mss == 16'd0) ? 16'd1 : r_mss;
    assign o_pop    = (r_state == BS_IDLE) && i_fq.valid;

    // Divider feed: an ack divides advance*54 by the segment size.
    assign ack_prod     = {6'd0, ack_cap(i_fq.item.ack_advance_bytes)} * {24'd0, HDR_BYTES};
    assign div_start    = o_pop && (i_fq.item.action == ACT_ACK);
    assign div_dividend = {2'b00, ack_prod};
    assign div_divisor  = mss_eff;

    // Decay divides the token count by 100 through a reciprocal product that
    // is registered every cycle; the count is stable while the item waits.
    assign dec_prod  = {32'd0, r_tokens} * {32'd0, DECAY_RECIP};
    assign ret_ready = div_done || (r_item.action == ACT_DECAY);

    tppq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    tppq_ram #(.WIDTH($bits(t_qent)), .DEPTH(QUEUE_DEPTH)) u_ram_high (
        .i_clk   (i_clk),
        .i_we    (we_h),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_hh),
        .o_rdata (rd_h)
    );

    tppq_ram #(.WIDTH($bits(t_qent)), .DEPTH(QUEUE_DEPTH)) u_ram_low (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_lh),
        .o_rdata (rd_l)
    );

    // Packet classification against the bucket and the queue fill.
    assign pkt_clear = r_item.high_priority ? (r_hc == '0) : (r_hc == '0 && r_lc == '0);
    assign pkt_fits  = tok_fits(r_cap, r_tokens, r_item.trigger_bytes);
    assign pkt_cnt   = r_item.high_priority ? r_hc : r_lc;
    assign pkt_head  = r_item.high_priority ? r_hh : r_lh;
    assign pkt_full  = pkt_cnt >= Q_CW'(QUEUE_DEPTH);
    assign slot_sum  = {1'b0, pkt_head} + pkt_cnt;
    assign waddr     = (slot_sum >= Q_CW'(QUEUE_DEPTH)) ?
                       Q_AW'(slot_sum - Q_CW'(QUEUE_DEPTH)) : Q_AW'(slot_sum);
    assign wdata     = '{tag: r_item.packet_tag, charge: r_item.trigger_bytes,
                         stamp: r_item.now_us};

    // Token return after a division.
    assign dec_amt    = (r_dec_q < DECAY_MIN) ? DECAY_MIN : r_dec_q;
    assign give_amt   = (r_item.action == ACT_ACK) ?
                        ({9'd0, ack_cap(r_item.ack_advance_bytes)} + {1'b0, div_quo}) :
                        {1'b0, dec_amt};
    assign ret_tokens = ({1'b0, r_tokens} >= give_amt) ? (r_tokens - give_amt[31:0]) : 32'd0;

    // Service evaluation of the registered head entry.
    assign ent      = r_sel ? rd_l : rd_h;
    assign sev_cnt  = r_sel ? r_lc : r_hc;
    assign sev_head = r_sel ? r_lh : r_hh;
    assign sev_fits = tok_fits(r_cap, r_tokens, ent.charge);
    assign sev_wait = r_item.now_us - ent.stamp;
    assign sev_tmo  = sev_wait >= r_maxd;
    assign sev_rel  = sev_fits || sev_tmo;
    assign sev_go   = sev_rel && (!r_held_v || out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_fq.valid) begin
                    unique case (i_fq.item.action)
                        ACT_PACKET:          n_state = BS_PKT;
                        ACT_ACK, ACT_DECAY:  n_state = BS_DIV;
                        default:             n_state = BS_SRD;
                    endcase
                end
            end
            BS_PKT:  n_state = BS_OUT;
            BS_DIV:  if (ret_ready) n_state = BS_OUT;
            BS_OUT:  if (out_free) n_state = BS_IDLE;
            BS_SRD: begin
                if (sev_cnt != '0 && r_k < SVC_CW'(MAX_SERVICE)) begin
                    n_state = BS_SEV;
                end else if (!(sev_cnt == '0 && !r_sel)) begin
                    n_state = BS_SFIN;
                end
            end
            BS_SEV: begin
                if (!sev_rel) begin
                    n_state = BS_SFIN;
                end else if (sev_go) begin
                    n_state = BS_SRD;
                end
            end
            BS_SFIN: if (!r_held_v || out_free) n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        n_tokens = r_tokens;
        n_hh     = r_hh;
        n_lh     = r_lh;
        n_hc     = r_hc;
        n_lc     = r_lc;
        n_item   = r_item;
        n_sel    = r_sel;
        n_k      = r_k;
        n_held_v = r_held_v;
        n_held   = r_held;
        n_res    = r_res;
        n_out_v  = r_out_v && !i_out_ready;
        n_out    = r_out;
        we_h     = 1'b0;
        we_l     = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_fq.valid) begin
                    n_item   = i_fq.item;
                    n_sel    = 1'b0;
                    n_k      = '0;
                    n_held_v = 1'b0;
                end
            end
            BS_PKT: begin
                n_res.result_tag = r_item.packet_tag;
                n_res.last       = 1'b1;
                if (r_item.trigger_bytes >= r_cap) begin
                    n_res.verdict = V_PASS;
                end else if (pkt_clear && pkt_fits) begin
                    n_res.verdict = V_PASS;
                    n_tokens      = r_tokens + r_item.trigger_bytes;
                end else if (pkt_full) begin
                    n_res.verdict = V_DROP;
                end else begin
                    n_res.verdict = V_QUEUED;
                    if (r_item.high_priority) begin
                        we_h = 1'b1;
                        n_hc = r_hc + Q_CW'(1);
                    end else begin
                        we_l = 1'b1;
                        n_lc = r_lc + Q_CW'(1);
                    end
                end
                n_res.tokens_level = n_tokens;
            end
            BS_DIV: begin
                if (ret_ready) begin
                    n_tokens = ret_tokens;
                    n_res    = '{result_tag: '0, verdict: V_PASS, last: 1'b1,
                                 tokens_level: ret_tokens};
                end
            end
            BS_OUT: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    n_out   = r_res;
                end
            end
            BS_SRD: begin
                if (sev_cnt == '0 && !r_sel) begin
                    n_sel = 1'b1;
                end
            end
            BS_SEV: begin
                if (sev_go) begin
                    if (r_held_v) begin
                        n_out_v = 1'b1;
                        n_out   = r_held;
                    end
                    n_tokens = sev_fits ? (r_tokens + ent.charge) : r_tokens;
                    n_held_v = 1'b1;
                    n_held   = '{result_tag: ent.tag,
                                 verdict: sev_fits ? V_TOKENS : V_TIMEOUT,
                                 last: 1'b0, tokens_level: n_tokens};
                    n_k      = r_k + SVC_CW'(1);
                    if (r_sel) begin
                        n_lh = (sev_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : sev_head + Q_AW'(1);
                        n_lc = r_lc - Q_CW'(1);
                    end else begin
                        n_hh = (sev_head == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : sev_head + Q_AW'(1);
                        n_hc = r_hc - Q_CW'(1);
                    end
                end
            end
            BS_SFIN: begin
                if (r_held_v && out_free) begin
                    n_out_v   = 1'b1;
                    n_out     = r_held;
                    n_out.last = 1'b1;
                    n_held_v  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_cap    <= CAP_RESET;
            r_maxd   <= DELAY_RESET;
            r_mss    <= MSS_RESET;
            r_tokens <= '0;
            r_hh     <= '0;
            r_lh     <= '0;
            r_hc     <= '0;
            r_lc     <= '0;
            r_sel    <= 1'b0;
            r_k      <= '0;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tokens <= n_tokens;
            r_hh     <= n_hh;
            r_lh     <= n_lh;
            r_hc     <= n_hc;
            r_lc     <= n_lc;
            r_sel    <= n_sel;
            r_k      <= n_k;
            r_held_v <= n_held_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY:  r_cap  <= i_cfg_data;
                    CFG_MAX_DELAY: r_maxd <= i_cfg_data;
                    CFG_SEGMENT:   r_mss  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_held  <= n_held;
        r_res   <= n_res;
        r_out   <= n_out;
        r_dec_q <= {5'd0, dec_prod[63:37]};
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    `TPPQ_ASSERT(a_fill_bound, r_hc <= Q_CW'(QUEUE_DEPTH) && r_lc <= Q_CW'(QUEUE_DEPTH), "queue fill above depth")
    `TPPQ_ASSERT(a_svc_bound, r_k <= SVC_CW'(MAX_SERVICE), "service released too many heads")
    `TPPQ_ASSERT_IMPL(a_held_svc, r_held_v, r_state == BS_SRD || r_state == BS_SEV || r_state == BS_SFIN, "held result outside service walk")
endmodule

// ===== hw/rtl/token_paced_priority_queues_unit.sv =====
// Token paced priority queues. Packet: classified in BS_PKT, its result passed
// to the output register from BS_OUT. Ack: waits on the 32-step segment size
// divider. Decay: uses the registered reciprocal product. Service: one queue
// RAM read and evaluate per released head, at most 64 heads. One item is worked
// on at a time behind a two-entry input queue. Synchronous active-low reset; no clearing pass.
module token_paced_priority_queues_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tppq_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tppq_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import tppq_pkg::*;

    // The front end only buffers input transfers so the upstream side keeps
    // moving while the back end walks queues or waits on the divider.
    t_fq  fq;
    logic pop;

    tppq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_pop      (pop),
        .o_fq       (fq)
    );

    // The back end owns the bucket, both queues and the result register,
    // which decouples it from a stalled consumer.
    tppq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_fq        (fq),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

// ===== tb/tppq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the token paced priority queues: watches the input, output and
// configuration ports, predicts every result and compares it. Needs tppq_pkg.
module tppq_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tppq_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tppq_pkg::t_out_item i_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import tppq_pkg::*;

    logic [31:0] cap_sh;
    logic [31:0] delay_sh;
    logic [15:0] mss_sh;
    logic [31:0] tokens;
    t_qent       slots [0:1][0:QUEUE_DEPTH-1];
    int          q_head [0:1];
    int          q_count [0:1];
    t_out_item   pending_results [$];
    int          errors;

    function automatic bit charge_tokens(input logic [31:0] amt);
        if (cap_sh >= tokens && (cap_sh - tokens) >= amt) begin
            tokens = tokens + amt;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void refund(input logic [63:0] amt);
        if ({32'd0, tokens} >= amt) tokens = tokens - amt[31:0];
        else tokens = '0;
    endfunction

    function automatic void expect_result(input logic [15:0] tag, input t_verdict v,
                                          input logic last);
        t_out_item r;
        r.result_tag   = tag;
        r.verdict      = v;
        r.last         = last;
        r.tokens_level = tokens;
        pending_results.push_back(r);
    endfunction

    // Release heads of one queue while they fit or have waited long enough.
    function automatic void release_heads(input int s, input logic [31:0] now, inout int k);
        t_qent    e;
        t_verdict v;
        while (k < MAX_SERVICE && q_count[s] > 0) begin
            e = slots[s][q_head[s]];
            if (charge_tokens(e.charge)) v = V_TOKENS;
            else if ((now - e.stamp) >= delay_sh) v = V_TIMEOUT;
            else break;
            expect_result(e.tag, v, 1'b0);
            k++;
            q_head[s] = (q_head[s] + 1) % QUEUE_DEPTH;
            q_count[s]--;
        end
    endfunction

    function automatic void predict_item(input t_in_item it);
        int          s;
        int          k;
        bit          clear;
        t_verdict    v;
        logic [63:0] mss;
        logic [63:0] adv;
        logic [31:0] d;
        t_out_item   r;
        case (t_action'(it.action))
            ACT_PACKET: begin
                s = it.high_priority ? 1 : 0;
                if (it.trigger_bytes >= cap_sh) begin
                    v = V_PASS;
                end else begin
                    clear = it.high_priority ? (q_count[1] == 0)
                                             : (q_count[1] == 0 && q_count[0] == 0);
                    if (clear && charge_tokens(it.trigger_bytes)) begin
                        v = V_PASS;
                    end else if (q_count[s] >= QUEUE_DEPTH) begin
                        v = V_DROP;
                    end else begin
                        slots[s][(q_head[s] + q_count[s]) % QUEUE_DEPTH] =
                            '{it.packet_tag, it.trigger_bytes, it.now_us};
                        q_count[s]++;
                        v = V_QUEUED;
                    end
                end
                expect_result(it.packet_tag, v, 1'b1);
            end
            ACT_ACK: begin
                mss = (mss_sh == 16'd0) ? 64'd1 : {48'd0, mss_sh};
                adv = (it.ack_advance_bytes > 32'd10485760) ? 64'd10485760
                                                             : {32'd0, it.ack_advance_bytes};
                refund(adv * (mss + 64'd54) / mss);
                expect_result('0, V_PASS, 1'b1);
            end
            ACT_DECAY: begin
                d = tokens / 32'd100;
                if (d < 32'd10240) d = 32'd10240;
                refund({32'd0, d});
                expect_result('0, V_PASS, 1'b1);
            end
            default: begin
                k = 0;
                release_heads(1, it.now_us, k);
                if (q_count[1] == 0) release_heads(0, it.now_us, k);
                // The final release of a service item carries the last flag.
                if (k > 0) begin
                    r = pending_results.pop_back();
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cap_sh   <= CAP_RESET;
            delay_sh <= DELAY_RESET;
            mss_sh   <= MSS_RESET;
            tokens   = '0;
            q_head   = '{0, 0};
            q_count  = '{0, 0};
            pending_results.delete();
            errors   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: tag %0h", i_out.result_tag);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out.result_tag !== want.result_tag) begin
                        $error("result_tag expected %0h got %0h", want.result_tag,
                               i_out.result_tag);
                        errors++;
                    end
                    if (i_out.verdict !== want.verdict) begin
                        $error("verdict expected %0d got %0d", want.verdict, i_out.verdict);
                        errors++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last expected %0b got %0b", want.last, i_out.last);
                        errors++;
                    end
                    if (i_out.tokens_level !== want.tokens_level) begin
                        $error("tokens_level expected %0d got %0d", want.tokens_level,
                               i_out.tokens_level);
                        errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_item(i_in);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CAPACITY:  cap_sh   <= i_cfg_data;
                    CFG_MAX_DELAY: delay_sh <= i_cfg_data;
                    CFG_SEGMENT:   mss_sh   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= pending_results.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench for token_paced_priority_queues_unit: clock, reset,
// stimulus and verdict. Depends on tppq_pkg, tppq_checker and the unit.
module tb;
    import tppq_pkg::*;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // Cycles allowed after the last result for a silent service item to finish.
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PRESSURE_PKTS = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          mismatches;
    int          outstanding;

    // Idling percentages of the current phase and the hold-off handshake
    // between the stimulus process and the receiver process.
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;
    int          holds_served;
    int          hold_left;
    int          quiet_cycles;

    // Copy of the capacity written last, used to aim charges near it.
    logic [31:0] cap_now;
    logic [31:0] clock_us;

    token_paced_priority_queues_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    tppq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mismatches),
        .o_pending   (outstanding)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Receiver: random stalls, or a long hold-off whenever one is requested.
    // The hold-off is counted here so that the sender keeps offering items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            holds_served <= 0;
            hold_left    <= 0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            i_out_ready  <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a run that stops moving items ends as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(input t_action act, input logic [15:0] tag,
                                           input logic [31:0] charge, input logic hi,
                                           input logic [31:0] adv, input logic [31:0] now);
        t_in_item it;
        it.action            = act;
        it.packet_tag        = tag;
        it.trigger_bytes     = charge;
        it.high_priority     = hi;
        it.ack_advance_bytes = adv;
        it.now_us            = now;
        return it;
    endfunction

    // Offers one item and returns once it has been transferred. Valid is only
    // lowered when the sender decides to idle, so back-to-back items never
    // see valid dropped and raised within one time step.
    task automatic send(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering and waits until every expected result has come, then
    // gives a silent service item time to finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_CAPACITY) cap_now = data;
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Charges spread over the whole range but mostly at or below a quarter of
    // the capacity, so that packets pass, queue and get released by either route.
    function automatic logic [31:0] pick_charge();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return cap_now;
            default: return $urandom_range(0, (cap_now > 32'd8) ? cap_now / 4 : 32'd2);
        endcase
    endfunction

    function automatic logic [31:0] pick_advance();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'd0;
            default: return $urandom_range(0, 200000);
        endcase
    endfunction

    // One well-formed burst: a few packets, maybe an ack or a decay, then a
    // service pass at a later time; now and then the clock jumps anywhere.
    task automatic random_burst(input int n_pkts);
        int          i;
        logic [31:0] step;
        for (i = 0; i < n_pkts; i++) begin
            clock_us = clock_us + $urandom_range(0, 3000);
            send(make_item(ACT_PACKET, 16'($urandom), pick_charge(), 1'($urandom_range(1)),
                           $urandom, clock_us));
        end
        case ($urandom_range(3))
            0: send(make_item(ACT_ACK, 16'($urandom), $urandom, 1'($urandom_range(1)),
                              pick_advance(), clock_us));
            1: send(make_item(ACT_DECAY, 16'($urandom), $urandom, 1'($urandom_range(1)),
                              $urandom, clock_us));
            default: ;
        endcase
        step = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 60000);
        clock_us = clock_us + step;
        send(make_item(ACT_SERVICE, 16'($urandom), $urandom, 1'($urandom_range(1)), $urandom,
                       clock_us));
    endtask

    initial begin
        int phase;
        int sent;
        int i;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in           <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_CAPACITY;
        i_cfg_data     <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        cap_now        = CAP_RESET;
        clock_us       = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset settings. Field extremes: zero charge,
        // all-ones charge, a charge just under capacity that fills the bucket.
        send(make_item(ACT_PACKET, 16'h0000, 32'd0, 1'b0, 32'd0, 32'd0));
        send(make_item(ACT_PACKET, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF));
        send(make_item(ACT_PACKET, 16'h1234, CAP_RESET - 1, 1'b1, 32'd0, 32'd5));
        // Nothing fits now: one packet per queue gets queued.
        send(make_item(ACT_PACKET, 16'h00A1, 32'd100, 1'b0, 32'd0, 32'd10));
        send(make_item(ACT_PACKET, 16'h00A2, 32'd100, 1'b1, 32'd0, 32'd10));
        // Service with nothing releasable produces no result at all.
        send(make_item(ACT_SERVICE, 16'h0, 32'd0, 1'b0, 32'd0, 32'd20));
        // Ack above the 10 MiB cap, then a decay; then both heads fit.
        send(make_item(ACT_ACK, 16'h5555, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd20));
        send(make_item(ACT_DECAY, 16'hAAAA, 32'd0, 1'b1, 32'd0, 32'd20));
        send(make_item(ACT_SERVICE, 16'h0, 32'd0, 1'b0, 32'd0, 32'd30));
        send(make_item(ACT_ACK, 16'h0, 32'd0, 1'b0, 32'd0, 32'd30));
        // Large acks saturate the count at zero; a decay at zero stays at zero.
        send(make_item(ACT_ACK, 16'h0, 32'd0, 1'b0, 32'd10485760, 32'd30));
        send(make_item(ACT_ACK, 16'h0, 32'd0, 1'b0, 32'd10485761, 32'd30));
        send(make_item(ACT_ACK, 16'h0, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd30));
        send(make_item(ACT_DECAY, 16'h0, 32'd0, 1'b0, 32'd0, 32'd30));
        // Fill the bucket again, queue a high packet and let it time out,
        // with the time difference wrapping past zero.
        send(make_item(ACT_PACKET, 16'h0B01, CAP_RESET - 1, 1'b1, 32'd0, 32'hFFFF_FF00));
        send(make_item(ACT_PACKET, 16'h0B02, 32'd5, 1'b1, 32'd0, 32'hFFFF_FF00));
        send(make_item(ACT_SERVICE, 16'h0, 32'd0, 1'b0, 32'd0, 32'd49000));
        send(make_item(ACT_SERVICE, 16'h0, 32'd0, 1'b0, 32'd0, DELAY_RESET + 32'd1000));
        drain();

        // Extremes: zero capacity passes everything, zero delay releases at
        // once, zero segment size acts as one. Index 3 must be ignored.
        write_reg(CFG_CAPACITY, 32'd0);
        write_reg(CFG_MAX_DELAY, 32'd0);
        write_reg(CFG_SEGMENT, 32'd0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        end_writes();
        send(make_item(ACT_PACKET, 16'h0C01, 32'd0, 1'b0, 32'd0, 32'd0));
        send(make_item(ACT_ACK, 16'h0, 32'd0, 1'b0, 32'd5, 32'd0));
        drain();

        // Tokens above capacity after a write: no charge fits until tokens fall.
        write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_DELAY, 32'hFFFF_FFFF);
        write_reg(CFG_SEGMENT, 32'h0000_FFFF);
        end_writes();
        send(make_item(ACT_PACKET, 16'h0D01, 32'd50000, 1'b0, 32'd0, 32'd0));
        drain();
        write_reg(CFG_CAPACITY, 32'd1000);
        end_writes();
        send(make_item(ACT_PACKET, 16'h0D02, 32'd10, 1'b0, 32'd0, 32'd0));
        send(make_item(ACT_PACKET, 16'h0D03, 32'd2000, 1'b0, 32'd0, 32'd0));
        send(make_item(ACT_ACK, 16'h0, 32'd0, 1'b0, 32'd1000000, 32'd0));
        send(make_item(ACT_SERVICE, 16'h0, 32'd0, 1'b0, 32'd0, 32'd1));
        drain();

        // Random part in four idling phases, with fresh settings per phase.
        sent = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_reg(CFG_CAPACITY, $urandom_range(20000, 400000));
            write_reg(CFG_MAX_DELAY, $urandom_range(0, 40000));
            write_reg(CFG_SEGMENT, $urandom_range(1, 65535));
            end_writes();
            while (sent < (phase + 1) * 18) begin
                i = $urandom_range(1, 6);
                random_burst(i);
                sent += i + 2;
            end
            drain();
        end

        // Pressure: the receiver holds off while the sender keeps offering
        // packets, so the result register and the input queue fill and the
        // input stalls. A service item then flushes the queued ones by timeout.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_CAPACITY, 32'd10);
        write_reg(CFG_MAX_DELAY, 32'd100);
        write_reg(CFG_SEGMENT, 32'd1460);
        end_writes();
        send(make_item(ACT_PACKET, 16'h0E00, 32'd9, 1'b1, 32'd0, 32'd0));
        hold_requests = hold_requests + 1;
        for (i = 0; i < PRESSURE_PKTS; i++)
            send(make_item(ACT_PACKET, i[15:0], 32'd5, 1'b1, 32'd0, 32'd1000));
        // Sender waits for every result before the flush.
        drain();
        send(make_item(ACT_SERVICE, 16'h0, 32'd0, 1'b0, 32'd0, 32'd5000));
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
